// ----- rtl/lfve_pkg.sv -----
// Shared constants and types of the leg flex velocity estimator.
package lfve_pkg;
  localparam int LEG_COUNT = 4;
  localparam int LEG_W = 2;
  localparam int CFG_AW = 4;
  localparam logic [CFG_AW-1:0] ADDR_TORQUE_RATE = 4'd0;
  localparam logic [CFG_AW-1:0] ADDR_TORQUE = 4'd4;
  localparam logic [CFG_AW-1:0] ADDR_POSITION = 4'd8;
  localparam logic [CFG_AW-1:0] ADDR_DAMPING = 4'd12;
  localparam logic signed [31:0] POSITION_COEF_RST = 32'sd65536;
  localparam int IN_W = 120;
  localparam int OUT_W = 136;

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // Status from the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction
endpackage

// ----- rtl/lfve_div.sv -----
// Restoring divider, one quotient bit a cycle, for the torque rate.
module lfve_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lfve_pkg::div_ctl_t       ctl,
  input  logic signed [48:0]       num,
  input  logic [15:0]              den,
  output lfve_pkg::div_sts_t       sts,
  output logic signed [31:0]       quo
);
  import lfve_pkg::*;

  logic [47:0] rem_r, rem_nxt;
  logic [47:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        neg_r, neg_nxt;
  logic [16:0] trial;
  logic [48:0] mag;
  logic signed [49:0] sq;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt = neg_r;
    mag = num[48] ? 49'(-num) : 49'(num);
    trial = {rem_r[15:0], q_r[47]} - {1'b0, den};
    if (ctl.start) begin
      rem_nxt = '0;
      q_nxt = mag[47:0];
      cnt_nxt = 6'd48;
      busy_nxt = 1'b1;
      neg_nxt = num[48];
    end else if (busy_r) begin
      if (!trial[16]) begin
        rem_nxt = {32'd0, trial[15:0]};
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = {32'd0, rem_r[14:0], q_r[47]};
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    neg_r <= neg_nxt;
  end

  assign sq = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
  assign quo = sat32(66'(sq));
  assign sts.busy = busy_r;
  assign sts.done = done_r;
endmodule

// ----- rtl/leg_flex_velocity_estimator.sv -----
// Top level of the leg flex velocity estimator: registers, leg state and sequencer.
//
// One input beat carries a sample of one leg; one output beat carries its result.
// Registers must be written through the cfg_ APB port only while the block is idle;
// the block itself does not enforce this. In swing or at touchdown the accepted
// sample goes from S_IDLE to S_OUT, which registers the result and raises
// out_tvalid. In stance the sample goes through a bit-serial divider for the
// torque rate and then through one shared 33x34 multiplier that is used six
// times; the divider is skipped when the time step is zero. The next sample is
// accepted the cycle after the result beat is taken.
// in_tready is high only while no sample is being worked on and no result
// waits in the output register. When the receiver stalls, the result holds in
// the output register and the next sample waits. Reset clears all leg state
// and returns the registers to their reset values; no clearing pass is needed.
module leg_flex_velocity_estimator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: leg, stance, torque, position, velocity, time_step (zero padded)
  input  logic [lfve_pkg::IN_W-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata: leg_out, flex_velocity, model_position, model_velocity,
  // model_acceleration (zero padded)
  output logic [lfve_pkg::OUT_W-1:0]    out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lfve_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import lfve_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_OUT} state_t;

  state_t state_r;
  logic signed [31:0] ktr_r, kt_r, kp_r, kd_r;
  logic               lst_r [LEG_COUNT];
  logic signed [31:0] pos_r [LEG_COUNT];
  logic signed [31:0] anc_r [LEG_COUNT];
  logic signed [31:0] vel_r [LEG_COUNT];
  logic signed [31:0] acc_r [LEG_COUNT];
  logic signed [31:0] ltq_r [LEG_COUNT];

  logic [LEG_W-1:0]   leg_r;
  logic signed [31:0] tau_r, qd_r;
  logic [15:0]        dt_r;
  logic signed [31:0] taud_r;
  logic [3:0]         step_r;
  logic signed [65:0] sum_r;
  logic signed [32:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [66:0] prod_r;
  logic signed [31:0] nacc_r, nvel_r;
  logic               ovld_r;
  logic [OUT_W-1:0]   odata_r;

  logic [LEG_W-1:0]   in_leg;
  logic               in_st;
  logic signed [31:0] in_tau, in_q, in_qd;
  logic [15:0]        in_dt;
  logic               wr;
  div_ctl_t           dctl;
  div_sts_t           dsts;
  logic signed [48:0] dnum;
  logic signed [31:0] dquo;
  logic signed [65:0] psh16, psh17;

  assign in_leg = in_tdata[1:0];
  assign in_st  = in_tdata[2];
  assign in_tau = in_tdata[34:3];
  assign in_q   = in_tdata[66:35];
  assign in_qd  = in_tdata[98:67];
  assign in_dt  = in_tdata[114:99];

  assign in_tready = (state_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tdata = odata_r;
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr)
      ADDR_TORQUE_RATE: cfg_prdata = ktr_r;
      ADDR_TORQUE:      cfg_prdata = kt_r;
      ADDR_POSITION:    cfg_prdata = kp_r;
      ADDR_DAMPING:     cfg_prdata = kd_r;
      default:          cfg_prdata = '0;
    endcase
  end

  assign dnum = 49'(33'(tau_r) - 33'(ltq_r[leg_r])) <<< 16;
  assign dctl.start = (state_r == S_DIV) && (dt_r != '0) && !dsts.busy && !dsts.done &&
                      step_r == 4'd0;

  lfve_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .num(dnum), .den(dt_r),
    .sts(dsts), .quo(dquo)
  );

  assign psh16 = 66'(prod_r >>> 16);
  assign psh17 = 66'(prod_r >>> 17);

  // Operand selection for the shared multiplier, at most one product a step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      4'd0: begin mul_a = 33'(ktr_r); mul_b = 34'(taud_r); end
      4'd1: begin mul_a = 33'(kt_r);  mul_b = 34'(tau_r); end
      4'd2: begin mul_a = 33'(kp_r);  mul_b = 34'(33'(pos_r[leg_r]) - 33'(anc_r[leg_r])); end
      4'd3: begin mul_a = 33'(kd_r);  mul_b = 34'(vel_r[leg_r]); end
      4'd5: begin mul_a = $signed({17'd0, dt_r}); mul_b = 34'(acc_r[leg_r]) + 34'(nacc_r); end
      4'd7: begin mul_a = $signed({17'd0, dt_r}); mul_b = 34'(nvel_r) + 34'(vel_r[leg_r]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r <= 1'b0;
      step_r <= '0;
      ktr_r <= '0;
      kt_r <= '0;
      kp_r <= POSITION_COEF_RST;
      kd_r <= '0;
      for (int i = 0; i < LEG_COUNT; i++) begin
        lst_r[i] <= 1'b0;
        pos_r[i] <= '0;
        anc_r[i] <= '0;
        vel_r[i] <= '0;
        acc_r[i] <= '0;
        ltq_r[i] <= '0;
      end
    end else begin
      if (wr) begin
        case (cfg_paddr)
          ADDR_TORQUE_RATE: ktr_r <= cfg_pwdata;
          ADDR_TORQUE:      kt_r <= cfg_pwdata;
          ADDR_POSITION:    kp_r <= cfg_pwdata;
          ADDR_DAMPING:     kd_r <= cfg_pwdata;
          default: ;
        endcase
      end
      if (ovld_r && out_tready) ovld_r <= 1'b0;
      prod_r <= mul_a * mul_b;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            leg_r <= in_leg;
            tau_r <= in_tau;
            qd_r <= in_qd;
            dt_r <= in_dt;
            step_r <= '0;
            lst_r[in_leg] <= in_st;
            if (!in_st) begin
              pos_r[in_leg] <= in_q;
              vel_r[in_leg] <= in_qd;
              state_r <= S_OUT;
            end else if (!lst_r[in_leg]) begin
              pos_r[in_leg] <= in_q;
              anc_r[in_leg] <= in_q;
              vel_r[in_leg] <= in_qd;
              acc_r[in_leg] <= '0;
              ltq_r[in_leg] <= in_tau;
              state_r <= S_OUT;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (dt_r == '0) begin
            taud_r <= '0;
            state_r <= S_MUL;
          end else if (dctl.start) begin
            step_r <= 4'd1;
          end else if (dsts.done) begin
            taud_r <= dquo;
            step_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          step_r <= step_r + 4'd1;
          // The product of step k is registered in prod_r and used at step k+1.
          case (step_r)
            4'd1: sum_r <= psh16;
            4'd2: sum_r <= sum_r + psh16;
            4'd3: sum_r <= sum_r - psh16;
            4'd4: nacc_r <= sat32(sum_r - psh16);
            4'd6: nvel_r <= sat32(66'(vel_r[leg_r]) + psh17);
            4'd8: begin
              pos_r[leg_r] <= sat32(66'(pos_r[leg_r]) + psh17);
              vel_r[leg_r] <= nvel_r;
              acc_r[leg_r] <= nacc_r;
              ltq_r[leg_r] <= tau_r;
              state_r <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: begin
          ovld_r <= 1'b1;
          odata_r <= {6'd0, acc_r[leg_r], vel_r[leg_r], pos_r[leg_r],
                      sat32(66'(qd_r) - 66'(vel_r[leg_r])), leg_r};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- tb/sv/lfve_checker.sv -----
// Checker for the leg flex velocity estimator: per-leg model prediction and result compare.
module lfve_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [lfve_pkg::IN_W-1:0]  in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [lfve_pkg::OUT_W-1:0] out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [lfve_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output int                         fail_count,
  output int                         pending_count,
  output int                         result_count
);
  import lfve_pkg::*;

  // Listed from the highest bits down, so leg sits in the lowest bits as on the bus.
  typedef struct packed {
    logic signed [31:0] macc;
    logic signed [31:0] mvel;
    logic signed [31:0] mpos;
    logic signed [31:0] flex_vel;
    logic [1:0]         leg;
  } leg_result_t;

  leg_result_t expected_results[$];

  longint c_rate, c_torque, c_pos, c_damp;
  logic   was_stance [LEG_COUNT];
  longint mpos_s [LEG_COUNT];
  longint anchor_s [LEG_COUNT];
  longint mvel_s [LEG_COUNT];
  longint macc_s [LEG_COUNT];
  longint torque_s [LEG_COUNT];

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // >>> on a signed longint is a floor shift.
  function automatic leg_result_t advance_leg(logic [IN_W-1:0] d);
    int unsigned l;
    logic st;
    longint tau, q, qd, dt, taud, acc, vel, dp;
    leg_result_t r;
    l = d[1:0];
    st = d[2];
    tau = longint'($signed(d[34:3]));
    q = longint'($signed(d[66:35]));
    qd = longint'($signed(d[98:67]));
    dt = longint'(d[114:99]);
    r = '0;
    r.leg = d[1:0];
    if (l >= LEG_COUNT) return r;
    if (!st) begin
      mpos_s[l] = q;
      mvel_s[l] = qd;
    end else if (!was_stance[l]) begin
      mpos_s[l] = q;
      anchor_s[l] = q;
      mvel_s[l] = qd;
      macc_s[l] = 0;
      torque_s[l] = tau;
    end else begin
      taud = 0;
      if (dt != 0) taud = clamp32(((tau - torque_s[l]) * 65536) / dt);
      acc = ((c_rate * taud) >>> 16) + ((c_torque * tau) >>> 16)
          - ((c_pos * (mpos_s[l] - anchor_s[l])) >>> 16)
          - ((c_damp * mvel_s[l]) >>> 16);
      acc = clamp32(acc);
      vel = clamp32(mvel_s[l] + (((macc_s[l] + acc) * dt) >>> 17));
      dp = ((vel + mvel_s[l]) * dt) >>> 17;
      mpos_s[l] = clamp32(mpos_s[l] + dp);
      mvel_s[l] = vel;
      macc_s[l] = acc;
      torque_s[l] = tau;
    end
    was_stance[l] = st;
    r.flex_vel = 32'(clamp32(qd - mvel_s[l]));
    r.mpos = 32'(mpos_s[l]);
    r.mvel = 32'(mvel_s[l]);
    r.macc = 32'(macc_s[l]);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", result_count, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    leg_result_t got, want;
    if (!rst_n) begin
      c_rate = 0; c_torque = 0; c_pos = 65536; c_damp = 0;
      for (int i = 0; i < LEG_COUNT; i++) begin
        was_stance[i] = 0; mpos_s[i] = 0; anchor_s[i] = 0;
        mvel_s[i] = 0; macc_s[i] = 0; torque_s[i] = 0;
      end
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
      pending_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          ADDR_TORQUE_RATE: c_rate = longint'($signed(cfg_pwdata));
          ADDR_TORQUE:      c_torque = longint'($signed(cfg_pwdata));
          ADDR_POSITION:    c_pos = longint'($signed(cfg_pwdata));
          ADDR_DAMPING:     c_damp = longint'($signed(cfg_pwdata));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_results.push_back(advance_leg(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[129:0];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat, leg_out", got.leg, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.leg != want.leg) report_mismatch("leg_out", got.leg, want.leg);
          if (got.flex_vel != want.flex_vel)
            report_mismatch("flex_velocity", got.flex_vel, want.flex_vel);
          if (got.mpos != want.mpos) report_mismatch("model_position", got.mpos, want.mpos);
          if (got.mvel != want.mvel) report_mismatch("model_velocity", got.mvel, want.mvel);
          if (got.macc != want.macc)
            report_mismatch("model_acceleration", got.macc, want.macc);
        end
        result_count++;
      end
      pending_count = expected_results.size();
    end
  end
endmodule

// ----- tb/sv/tb_leg_flex_velocity_estimator.sv -----
// Testbench top for the leg flex velocity estimator: stimulus, configuration and verdict.
module tb_leg_flex_velocity_estimator;
  import lfve_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int fail_count, pending_count, result_count;
  int cycle_count = 0;
  int hold_off = 0;
  int stance_beats = 0;

  localparam int CYCLE_LIMIT = 1000000;

  always #5 clk = ~clk;

  leg_flex_velocity_estimator i_dut (.*);
  lfve_checker i_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off requested by the sender side.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_off > 0) begin
      out_tready <= 0;
      hold_off <= hold_off - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: out_tready <= 0;
        2: out_tready <= ($urandom_range(0, 4) == 0);
        default: out_tready <= 1;
      endcase
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // The valid stays high into the next beat when there is no gap; wait_idle drops it.
  task automatic send_sample(logic [1:0] leg, logic st, logic [31:0] tau, logic [31:0] q,
                             logic [31:0] qd, logic [15:0] dt);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 150) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {5'd0, dt, qd, q, tau, st, leg};
    if (st) stance_beats++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 200000))
                                     : -32'($urandom_range(0, 200000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic run_stride(int n);
    logic [1:0] leg;
    logic [15:0] dt;
    for (int i = 0; i < n; i++) begin
      leg = $urandom_range(0, 3);
      dt = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      if ($urandom_range(0, 9) == 0) dt = 0;
      // Mostly stance runs so that the model integrates over several samples.
      send_sample(leg, $urandom_range(0, 5) != 0, rand_word(), rand_word(), rand_word(), dt);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // Directed: reset coefficients, swing, touchdown, stance, zero step, extremes.
    send_sample(0, 0, 32'h0, 32'h7fffffff, 32'h80000000, 16'hffff);
    send_sample(0, 1, 32'h00010000, 32'h00001000, 32'h0, 16'd655);
    send_sample(0, 1, 32'h00030000, 32'h0, 32'h100, 16'd655);
    send_sample(0, 1, 32'h80000000, 32'h0, 32'h100, 16'd0);
    send_sample(1, 1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'd1);
    send_sample(1, 1, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'hffff);
    send_sample(1, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff);
    send_sample(2, 1, 32'h0, 32'h0, 32'h0, 16'd1);
    send_sample(3, 1, 32'h12345678, 32'h87654321, 32'h0, 16'd100);
    send_sample(3, 1, 32'hedcba987, 32'h0, 32'h0, 16'd100);
    wait_idle();
    write_reg(ADDR_TORQUE_RATE, 32'h7fffffff);
    write_reg(ADDR_TORQUE, 32'h80000000);
    write_reg(ADDR_POSITION, 32'h7fffffff);
    write_reg(ADDR_DAMPING, 32'h80000000);
    send_sample(2, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff);
    send_sample(2, 1, 32'h80000000, 32'h80000000, 32'h80000000, 16'hffff);
    send_sample(3, 1, 32'h80000000, 32'h0, 32'h0, 16'd1);
    // Long receiver stall while the sender keeps offering samples.
    hold_off = 400;
    run_stride(6);
    wait_idle();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ADDR_TORQUE_RATE, rand_coef());
      write_reg(ADDR_TORQUE, rand_coef());
      write_reg(ADDR_POSITION, rand_coef());
      write_reg(ADDR_DAMPING, rand_coef());
      run_stride(95);
      wait_idle();
    end
    $display("covered %0d results, %0d stance samples, 8 coefficient settings",
             result_count, stance_beats);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/lfve_pkg.sv
rtl/lfve_div.sv
rtl/leg_flex_velocity_estimator.sv
tb/sv/lfve_checker.sv
tb/sv/tb_leg_flex_velocity_estimator.sv
